FILE: design/fpma_pkg.sv
// shared types, codes and sizes of the flash page map allocator
package fpma_pkg;

	localparam int PHYS_BLOCKS       = 64;
	localparam int PAGES_PER_BLOCK   = 64;
	localparam int MAX_LOGICAL_PAGES = 4096;
	localparam int TOTAL_PAGES       = PHYS_BLOCKS * PAGES_PER_BLOCK;

	localparam int BLK_W = 6;
	localparam int PG_W  = 6;
	localparam int LPN_W = 12;
	localparam int IDX_W = BLK_W + PG_W;
	localparam int FP_W  = PG_W + 1;
	localparam int CNT_W = 7;
	localparam int LP_W  = 13;
	localparam int GC_W  = 7;

	localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

	localparam int FWD_W = 1 + BLK_W + PG_W;
	localparam int REV_W = 1 + LPN_W;

	typedef enum logic [2:0] {
		OP_LOOKUP_L2P = 3'd0,
		OP_LOOKUP_P2L = 3'd1,
		OP_SET_L2P    = 3'd2,
		OP_SET_P2L    = 3'd3,
		OP_ALLOC_PAGE = 3'd4,
		OP_NEXT_BLOCK = 3'd5,
		OP_FREE_BLOCK = 3'd6,
		OP_QUERY_BLOCK = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		STS_OK         = 3'd0,
		STS_LPN_RANGE  = 3'd1,
		STS_PPN_RANGE  = 3'd2,
		STS_FRONT_FULL = 3'd3,
		STS_NO_FREE    = 3'd4,
		STS_NOT_FULL   = 3'd5,
		STS_NOT_FREE   = 3'd6,
		STS_NOT_VALID  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		BLK_FREE     = 2'd0,
		BLK_FRONTIER = 2'd1,
		BLK_FULL     = 2'd2
	} blk_state_t;

	typedef enum logic [1:0] {
		PG_FREE  = 2'd0,
		PG_LIVE  = 2'd1,
		PG_STALE = 2'd2
	} pg_state_t;

	typedef enum logic {
		CFG_LOGICAL_PAGES = 1'b0,
		CFG_GC_THRESHOLD  = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_MARK_OLD,
		S_MARK_NEW,
		S_WALK,
		S_FIN
	} fsm_t;

	// one access to the per-block tables; addr is used for the read as well
	typedef struct packed {
		logic             stat_we;
		logic             cnt_we;
		logic [BLK_W-1:0] addr;
		blk_state_t       stat;
		logic [CNT_W-1:0] cnt;
	} blk_req_t;

endpackage

FILE: design/fpma_ram.sv
// generic single-port synchronous ram with registered read
module fpma_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: design/fpma_blk_tbl.sv
// per-block status and invalid page count tables with reset valid bits
module fpma_blk_tbl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fpma_pkg::blk_req_t               req,
	output fpma_pkg::blk_state_t             stat_rd,
	output logic [fpma_pkg::CNT_W-1:0]       cnt_rd
);
	import fpma_pkg::*;

	blk_state_t       stat_mem [PHYS_BLOCKS];
	logic [CNT_W-1:0] cnt_mem  [PHYS_BLOCKS];
	logic [PHYS_BLOCKS-1:0] stat_vld_q;
	logic [PHYS_BLOCKS-1:0] cnt_vld_q;

	blk_state_t       stat_raw_q;
	logic [CNT_W-1:0] cnt_raw_q;
	logic             stat_hit_q;
	logic             cnt_hit_q;
	logic             addr_zero_q;

	always_ff @(posedge clk) begin
		if (req.stat_we) begin
			stat_mem[req.addr] <= req.stat;
		end
		if (req.cnt_we) begin
			cnt_mem[req.addr] <= req.cnt;
		end
		stat_raw_q  <= stat_mem[req.addr];
		cnt_raw_q   <= cnt_mem[req.addr];
		addr_zero_q <= (req.addr == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_vld_q <= '0;
			cnt_vld_q  <= '0;
			stat_hit_q <= 1'b0;
			cnt_hit_q  <= 1'b0;
		end else begin
			stat_hit_q <= stat_vld_q[req.addr];
			cnt_hit_q  <= cnt_vld_q[req.addr];
			if (req.stat_we) begin
				stat_vld_q[req.addr] <= 1'b1;
			end
			if (req.cnt_we) begin
				cnt_vld_q[req.addr] <= 1'b1;
			end
		end
	end

	// unwritten entries read as reset: block 0 is the frontier, all others free
	always_comb begin
		if (stat_hit_q) begin
			stat_rd = stat_raw_q;
		end else if (addr_zero_q) begin
			stat_rd = BLK_FRONTIER;
		end else begin
			stat_rd = BLK_FREE;
		end
		cnt_rd = cnt_hit_q ? cnt_raw_q : '0;
	end

endmodule

FILE: design/flash_page_map_allocator_unit.sv
// flash page map allocator: command sequencer around the map and state memories
// map commands, alloc page and query block: accept, then a read-modify-write execute state
// that also loads the output register when it is free, else the result is loaded from S_FIN
// next block scans the block table one entry a cycle, then marks the old frontier full and the new one frontier
// free block walks its pages one a cycle, marking each page free
// after reset a clearing pass runs over all 4096 entries of the map memories with in_ready low
module flash_page_map_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [2:0]                        op,
	input  logic [fpma_pkg::LPN_W-1:0]        logical_page,
	input  logic [fpma_pkg::BLK_W-1:0]        phys_block,
	input  logic [fpma_pkg::PG_W-1:0]         phys_page,
	input  logic                              map_valid,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        status,
	output logic                              entry_valid,
	output logic [fpma_pkg::LPN_W-1:0]        out_logical_page,
	output logic [fpma_pkg::BLK_W-1:0]        out_block,
	output logic [fpma_pkg::PG_W-1:0]         out_page,
	output logic [1:0]                        block_state,
	output logic [fpma_pkg::CNT_W-1:0]        invalid_count,
	output logic [fpma_pkg::CNT_W-1:0]        free_blocks,
	output logic                              gc_needed,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [fpma_pkg::LP_W-1:0]         cfg_data
);
	import fpma_pkg::*;

	fsm_t state_q, state_d;

	op_t              op_q;
	logic [LPN_W-1:0] lpn_q;
	logic [BLK_W-1:0] blk_q;
	logic [PG_W-1:0]  pg_q;
	logic             mv_q;

	logic [LP_W-1:0]  logical_pages_q;
	logic [GC_W-1:0]  gc_threshold_q;
	logic [BLK_W-1:0] frontier_blk_q;
	logic [FP_W-1:0]  frontier_pg_q;
	logic [CNT_W-1:0] fbc_q;
	logic [IDX_W-1:0] clr_q;
	logic [BLK_W-1:0] scan_q;
	logic [BLK_W-1:0] found_q;
	logic [PG_W-1:0]  walk_q;

	status_t          res_st_q;
	logic             res_ev_q;
	logic [LPN_W-1:0] res_olpn_q;
	logic [BLK_W-1:0] res_oblk_q;
	logic [PG_W-1:0]  res_opg_q;
	logic [1:0]       res_bst_q;
	logic [CNT_W-1:0] res_icnt_q;

	logic             out_valid_q;

	// memory ports
	logic             fwd_we;
	logic [IDX_W-1:0] fwd_addr;
	logic [FWD_W-1:0] fwd_wdata, fwd_rdata;
	logic             rev_we;
	logic [IDX_W-1:0] rp_addr;
	logic [REV_W-1:0] rev_wdata, rev_rdata;
	logic             ps_we;
	logic [1:0]       ps_wdata, ps_rdata;
	blk_req_t         blk_req;
	blk_state_t       stat_rd;
	logic [CNT_W-1:0] cnt_rd;

	// execute-cycle results
	status_t          ex_st;
	logic             ex_ev;
	logic [LPN_W-1:0] ex_olpn;
	logic [BLK_W-1:0] ex_oblk;
	logic [PG_W-1:0]  ex_opg;
	logic [1:0]       ex_bst;
	logic [CNT_W-1:0] ex_icnt;

	logic accept;
	logic out_free;
	logic lpn_ok;
	logic front_full;
	logic simple_op;
	logic out_load;
	logic [CNT_W-1:0] cnt_inc;

	fpma_ram #(.W(FWD_W), .D(MAX_LOGICAL_PAGES)) u_fwd (
		.clk(clk), .we(fwd_we), .addr(fwd_addr), .wdata(fwd_wdata), .rdata(fwd_rdata)
	);

	fpma_ram #(.W(REV_W), .D(TOTAL_PAGES)) u_rev (
		.clk(clk), .we(rev_we), .addr(rp_addr), .wdata(rev_wdata), .rdata(rev_rdata)
	);

	fpma_ram #(.W(2), .D(TOTAL_PAGES)) u_ps (
		.clk(clk), .we(ps_we), .addr(rp_addr), .wdata(ps_wdata), .rdata(ps_rdata)
	);

	fpma_blk_tbl u_blk (
		.clk(clk), .arst_n(arst_n), .req(blk_req), .stat_rd(stat_rd), .cnt_rd(cnt_rd)
	);

	assign in_ready   = (state_q == S_IDLE);
	assign accept     = in_valid && in_ready;
	assign cfg_ready  = 1'b1;
	assign out_free   = !out_valid_q || out_ready;
	assign lpn_ok     = ({1'b0, lpn_q} < logical_pages_q);
	assign front_full = (frontier_pg_q >= FP_W'(PAGES_PER_BLOCK));
	assign simple_op  = (op_q != OP_NEXT_BLOCK) && (op_q != OP_FREE_BLOCK);
	assign out_load   = ((state_q == S_EXEC) && simple_op && out_free) ||
		((state_q == S_FIN) && out_free);
	assign cnt_inc    = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_NEXT_BLOCK) begin
					state_d = S_SCAN;
				end else if (op_q == OP_FREE_BLOCK) begin
					state_d = S_WALK;
				end else begin
					state_d = out_free ? S_IDLE : S_FIN;
				end
			end
			S_SCAN: begin
				if (stat_rd == BLK_FREE) begin
					state_d = S_MARK_OLD;
				end else if (scan_q == '1) begin
					state_d = S_FIN;
				end
			end
			S_MARK_OLD: state_d = S_MARK_NEW;
			S_MARK_NEW: state_d = S_FIN;
			S_WALK: begin
				if (walk_q == '1) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		fwd_we       = 1'b0;
		fwd_addr     = lpn_q;
		fwd_wdata    = '0;
		rev_we       = 1'b0;
		rp_addr      = {blk_q, pg_q};
		rev_wdata    = '0;
		ps_we        = 1'b0;
		ps_wdata     = PG_FREE;
		blk_req      = '0;
		blk_req.addr = blk_q;
		blk_req.stat = BLK_FREE;
		case (state_q)
			S_CLEAR: begin
				fwd_we   = 1'b1;
				fwd_addr = clr_q;
				rev_we   = 1'b1;
				ps_we    = 1'b1;
				rp_addr  = clr_q;
			end
			S_IDLE: begin
				fwd_addr     = logical_page;
				blk_req.addr = phys_block;
				if (op_t'(op) == OP_ALLOC_PAGE) begin
					rp_addr = {frontier_blk_q, frontier_pg_q[PG_W-1:0]};
				end else begin
					rp_addr = {phys_block, phys_page};
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_SET_L2P: begin
						fwd_we    = lpn_ok;
						fwd_wdata = mv_q ? {1'b1, blk_q, pg_q} : '0;
					end
					OP_SET_P2L: begin
						rev_we    = 1'b1;
						rev_wdata = mv_q ? {1'b1, lpn_q} : '0;
						ps_we     = 1'b1;
						ps_wdata  = mv_q ? PG_LIVE : PG_STALE;
						blk_req.cnt_we = !mv_q;
						blk_req.cnt    = cnt_inc;
					end
					OP_FREE_BLOCK: begin
						blk_req.stat_we = 1'b1;
						blk_req.cnt_we  = 1'b1;
						blk_req.stat    = BLK_FREE;
						blk_req.cnt     = '0;
					end
					OP_NEXT_BLOCK: begin
						blk_req.addr = '0;
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				blk_req.addr = scan_q + 1'b1;
			end
			S_MARK_OLD: begin
				blk_req.stat_we = 1'b1;
				blk_req.addr    = frontier_blk_q;
				blk_req.stat    = BLK_FULL;
			end
			S_MARK_NEW: begin
				blk_req.stat_we = 1'b1;
				blk_req.addr    = found_q;
				blk_req.stat    = BLK_FRONTIER;
			end
			S_WALK: begin
				ps_we    = 1'b1;
				ps_wdata = PG_FREE;
				rp_addr  = {blk_q, walk_q};
			end
			default: ;
		endcase
	end

	// command results from the data read at accept
	// block and page fields cannot exceed the geometry, so address range errors never arise
	always_comb begin
		ex_st   = STS_OK;
		ex_ev   = 1'b0;
		ex_olpn = '0;
		ex_oblk = '0;
		ex_opg  = '0;
		ex_bst  = '0;
		ex_icnt = '0;
		case (op_q)
			OP_LOOKUP_L2P: begin
				if (!lpn_ok) begin
					ex_st = STS_LPN_RANGE;
				end else if (fwd_rdata[FWD_W-1]) begin
					ex_ev   = 1'b1;
					ex_oblk = fwd_rdata[PG_W +: BLK_W];
					ex_opg  = fwd_rdata[PG_W-1:0];
				end
			end
			OP_LOOKUP_P2L: begin
				if (rev_rdata[REV_W-1]) begin
					ex_ev   = 1'b1;
					ex_olpn = rev_rdata[LPN_W-1:0];
				end
			end
			OP_SET_L2P: begin
				if (!lpn_ok) ex_st = STS_LPN_RANGE;
			end
			OP_SET_P2L: begin
				if (mv_q) begin
					if (!lpn_ok) begin
						ex_st = STS_LPN_RANGE;
					end else if (ps_rdata != PG_FREE) begin
						ex_st = STS_NOT_FREE;
					end
				end else if (ps_rdata != PG_LIVE) begin
					ex_st = STS_NOT_VALID;
				end
			end
			OP_ALLOC_PAGE: begin
				if (front_full) begin
					ex_st = STS_FRONT_FULL;
				end else begin
					ex_ev   = 1'b1;
					ex_oblk = frontier_blk_q;
					ex_opg  = frontier_pg_q[PG_W-1:0];
					if (ps_rdata != PG_FREE) ex_st = STS_NOT_FREE;
				end
			end
			OP_QUERY_BLOCK: begin
				ex_bst  = stat_rd;
				ex_icnt = cnt_rd;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			logical_pages_q <= LP_W'(3072);
			gc_threshold_q  <= GC_W'(16);
			frontier_blk_q  <= '0;
			frontier_pg_q   <= '0;
			fbc_q           <= CNT_W'(PHYS_BLOCKS - 1);
			clr_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LOGICAL_PAGES: logical_pages_q <= cfg_data;
					CFG_GC_THRESHOLD:  gc_threshold_q  <= cfg_data[GC_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_EXEC && op_q == OP_ALLOC_PAGE && !front_full) begin
				frontier_pg_q <= frontier_pg_q + 1'b1;
			end
			if (state_q == S_EXEC && op_q == OP_FREE_BLOCK && fbc_q != CNT_MAX) begin
				fbc_q <= fbc_q + 1'b1;
			end
			if (state_q == S_MARK_NEW) begin
				frontier_blk_q <= found_q;
				frontier_pg_q  <= '0;
				if (fbc_q != '0) fbc_q <= fbc_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(op);
			lpn_q <= logical_page;
			blk_q <= phys_block;
			pg_q  <= phys_page;
			mv_q  <= map_valid;
		end
		case (state_q)
			S_EXEC: begin
				scan_q     <= '0;
				walk_q     <= '0;
				res_st_q   <= ex_st;
				res_ev_q   <= ex_ev;
				res_olpn_q <= ex_olpn;
				res_oblk_q <= ex_oblk;
				res_opg_q  <= ex_opg;
				res_bst_q  <= ex_bst;
				res_icnt_q <= ex_icnt;
			end
			S_SCAN: begin
				scan_q  <= scan_q + 1'b1;
				found_q <= scan_q;
				if (stat_rd != BLK_FREE && scan_q == '1) begin
					res_st_q <= STS_NO_FREE;
				end
			end
			S_MARK_NEW: begin
				res_st_q   <= front_full ? STS_OK : STS_NOT_FULL;
				res_ev_q   <= 1'b1;
				res_oblk_q <= found_q;
			end
			S_WALK: begin
				walk_q <= walk_q + 1'b1;
			end
			default: ;
		endcase
		if (out_load) begin
			// simple commands go straight from the execute cycle
			if (state_q == S_EXEC) begin
				status           <= ex_st;
				entry_valid      <= ex_ev;
				out_logical_page <= ex_olpn;
				out_block        <= ex_oblk;
				out_page         <= ex_opg;
				block_state      <= ex_bst;
				invalid_count    <= ex_icnt;
			end else begin
				status           <= res_st_q;
				entry_valid      <= res_ev_q;
				out_logical_page <= res_olpn_q;
				out_block        <= res_oblk_q;
				out_page         <= res_opg_q;
				block_state      <= res_bst_q;
				invalid_count    <= res_icnt_q;
			end
			free_blocks <= fbc_q;
			gc_needed   <= (fbc_q < gc_threshold_q);
		end
	end

	assign out_valid = out_valid_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_EXEC)
		else $error("accepted item did not enter execute");

	a_frontier_range: assert property (@(posedge clk) disable iff (!arst_n)
		frontier_pg_q <= FP_W'(PAGES_PER_BLOCK))
		else $error("frontier page beyond block");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !(fwd_we || rev_we || ps_we || blk_req.stat_we || blk_req.cnt_we))
		else $error("memory write while idle");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished result not loaded");

endmodule
